FILE: rtl/wav_pcm_to_stereo16_resampler_macros.svh
// assertion macros shared by the resampler modules
`ifndef WAV_PCM_TO_STEREO16_RESAMPLER_MACROS_SVH
`define WAV_PCM_TO_STEREO16_RESAMPLER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define WP2S_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// antecedent in one cycle implies consequent in the next
`define WP2S_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/wp2s_pkg.sv
// shared types, codes and constants of the pcm to stereo16 resampler
`timescale 1ns / 1ps
package wp2s_pkg;

  // sample format codes
  localparam logic [2:0] FMT_PCM8  = 3'd0;
  localparam logic [2:0] FMT_PCM16 = 3'd1;
  localparam logic [2:0] FMT_PCM24 = 3'd2;
  localparam logic [2:0] FMT_PCM32 = 3'd3;
  localparam logic [2:0] FMT_FLOAT = 3'd4;

  // register indexes
  localparam logic [1:0] REG_FORMAT   = 2'd0;
  localparam logic [1:0] REG_CHANNELS = 2'd1;
  localparam logic [1:0] REG_IN_RATE  = 2'd2;
  localparam logic [1:0] REG_OUT_RATE = 2'd3;

  // register reset values
  localparam logic [2:0]  RST_FORMAT   = FMT_PCM16;
  localparam logic [1:0]  RST_CHANNELS = 2'd2;
  localparam logic [16:0] RST_RATE     = 17'd48000;

  // output items per frame at most
  localparam logic [3:0] MAX_RUN = 4'd12;

  // float conversion constants
  localparam logic [14:0] FLOAT_SCALE  = 15'd32767;
  localparam logic [7:0]  EXP_ONE      = 8'd127;
  localparam logic [7:0]  EXP_ALL      = 8'hFF;
  localparam logic [7:0]  SHIFT_DENORM = 8'd149;
  localparam logic [7:0]  SHIFT_BASE   = 8'd150;
  localparam logic [7:0]  SHIFT_MAX    = 8'd38;

  typedef struct packed {
    logic [2:0]  fmt;
    logic [1:0]  channels;
    logic [16:0] in_rate;
    logic [16:0] out_rate;
  } cfg_t;

  typedef struct packed {
    logic [15:0] left;
    logic [15:0] right;
    logic        clr_acc;
  } frame_t;

  // bytes per sample, zero for an unknown format
  function automatic logic [2:0] bytes_for_format(input logic [2:0] fmt);
    logic [2:0] n;
    case (fmt)
      FMT_PCM8:  n = 3'd1;
      FMT_PCM16: n = 3'd2;
      FMT_PCM24: n = 3'd3;
      FMT_PCM32: n = 3'd4;
      FMT_FLOAT: n = 3'd4;
      default:   n = 3'd0;
    endcase
    return n;
  endfunction

endpackage

FILE: rtl/wav_pcm_to_stereo16_resampler.sv
// Flow: a byte that completes no sample is taken while the front part stays ready; a byte that
// completes a sample passes the front states in order (gather, multiply, convert), held in
// convert while the queue is full and a frame is to be pushed. The back part takes a frame from
// the two-entry queue, emits 1 item per cycle of the run while the receiver takes them, then
// closes the run. The front part takes no new byte until a completed sample has left convert.
// Reset is asynchronous, active low, and sets registers and state to their reset values.
`timescale 1ns / 1ps
module wav_pcm_to_stereo16_resampler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] left_sample_o,
  output logic [15:0] right_sample_o,
  output logic        last_of_run_o
);

  wp2s_pkg::cfg_t   cfg_q, cfg_d;
  wp2s_pkg::frame_t push_frame, pop_frame;
  logic             push, full, pop, frm_valid, wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        wp2s_pkg::REG_FORMAT:   cfg_d.fmt      = pwdata[2:0];
        wp2s_pkg::REG_CHANNELS: cfg_d.channels = pwdata[1:0];
        wp2s_pkg::REG_IN_RATE:  cfg_d.in_rate  = pwdata[16:0];
        wp2s_pkg::REG_OUT_RATE: cfg_d.out_rate = pwdata[16:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      wp2s_pkg::REG_FORMAT:   prdata = {29'd0, cfg_q.fmt};
      wp2s_pkg::REG_CHANNELS: prdata = {30'd0, cfg_q.channels};
      wp2s_pkg::REG_IN_RATE:  prdata = {15'd0, cfg_q.in_rate};
      wp2s_pkg::REG_OUT_RATE: prdata = {15'd0, cfg_q.out_rate};
      default:                prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{fmt: wp2s_pkg::RST_FORMAT, channels: wp2s_pkg::RST_CHANNELS,
                 in_rate: wp2s_pkg::RST_RATE, out_rate: wp2s_pkg::RST_RATE};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // front part: bytes to frames
  wp2s_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .start_of_data_i (start_of_data_i),
    .push_o          (push),
    .frame_o         (push_frame),
    .full_i          (full)
  );

  // frame queue
  wp2s_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_frame),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (frm_valid),
    .data_o  (pop_frame)
  );

  // back part: rate conversion
  wp2s_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .frm_valid_i    (frm_valid),
    .frm_i          (pop_frame),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

FILE: rtl/wp2s_fifo.sv
// two-entry frame queue between the front and back parts
`timescale 1ns / 1ps
`include "wav_pcm_to_stereo16_resampler_macros.svh"
module wp2s_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  wp2s_pkg::frame_t data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output wp2s_pkg::frame_t data_o
);

  wp2s_pkg::frame_t mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // pointer and count update
  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  `WP2S_ASSERT(a_no_push_full, clk_i, rst_ni, !(push_i && full_o), "frame pushed into full queue")

endmodule

FILE: rtl/wp2s_front.sv
// byte gathering, sample conversion and channel pairing
`timescale 1ns / 1ps
`include "wav_pcm_to_stereo16_resampler_macros.svh"
module wp2s_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wp2s_pkg::cfg_t   cfg_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             start_of_data_i,
  output logic             push_o,
  output wp2s_pkg::frame_t frame_o,
  input  logic             full_i
);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_CONV
  } state_e;

  state_e      state_q, state_d;
  logic [31:0] gather_q, gather_d;
  logic [2:0]  idx_q, idx_d;
  logic [15:0] held_q, held_d;
  logic        phase_q, phase_d;
  logic        clr_pend_q, clr_pend_d;
  logic [38:0] prod_q, prod_d;
  logic [7:0]  sh_q, sh_d;

  logic [31:0] base_gather, ins;
  logic [2:0]  base_idx, idx_next, need;
  logic [23:0] mant;
  logic [7:0]  ex;
  logic [38:0] shifted;
  logic [15:0] mag, smp;
  logic        stereo;

  assign in_ready_o = (state_q == F_IDLE);
  assign need       = wp2s_pkg::bytes_for_format(cfg_i.fmt);
  assign stereo     = cfg_i.channels[1];
  assign ex         = gather_q[30:23];
  assign mant       = (ex == 8'd0) ? {1'b0, gather_q[22:0]} : {1'b1, gather_q[22:0]};
  assign shifted    = prod_q >> sh_q[5:0];

  // byte placement
  always_comb begin
    base_gather = start_of_data_i ? 32'd0 : gather_q;
    base_idx    = start_of_data_i ? 3'd0 : idx_q;
    idx_next    = base_idx + 3'd1;
    ins         = base_idx[2] ? 32'd0 : ({24'd0, data_byte_i} << {base_idx[1:0], 3'b000});
  end

  // sample conversion to signed 16 bits
  always_comb begin
    if (ex == wp2s_pkg::EXP_ALL && gather_q[22:0] != 23'd0) begin
      mag = 16'd0;
    end else if (ex >= wp2s_pkg::EXP_ONE) begin
      mag = {1'b0, wp2s_pkg::FLOAT_SCALE};
    end else if (sh_q > wp2s_pkg::SHIFT_MAX) begin
      mag = 16'd0;
    end else begin
      mag = {1'b0, shifted[14:0]};
    end
    case (cfg_i.fmt)
      wp2s_pkg::FMT_PCM8:  smp = {gather_q[7:0] ^ 8'h80, 8'h00};
      wp2s_pkg::FMT_PCM16: smp = gather_q[15:0];
      wp2s_pkg::FMT_PCM24: smp = gather_q[23:8];
      wp2s_pkg::FMT_PCM32: smp = gather_q[31:16];
      default:             smp = gather_q[31] ? (16'd0 - mag) : mag;
    endcase
  end

  // control
  always_comb begin
    state_d    = state_q;
    gather_d   = gather_q;
    idx_d      = idx_q;
    held_d     = held_q;
    phase_d    = phase_q;
    clr_pend_d = clr_pend_q;
    prod_d     = prod_q;
    sh_d       = sh_q;
    push_o     = 1'b0;
    frame_o    = '{left: stereo ? held_q : smp, right: smp, clr_acc: clr_pend_q};
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          if (start_of_data_i) begin
            gather_d   = 32'd0;
            idx_d      = 3'd0;
            held_d     = 16'd0;
            phase_d    = 1'b0;
            clr_pend_d = 1'b1;
          end
          if (need != 3'd0) begin
            gather_d = base_gather | ins;
            idx_d    = idx_next;
            if (idx_next >= need) begin
              idx_d   = 3'd0;
              state_d = F_MUL;
            end
          end
        end
      end
      F_MUL: begin
        prod_d  = mant * wp2s_pkg::FLOAT_SCALE;
        sh_d    = (ex == 8'd0) ? wp2s_pkg::SHIFT_DENORM : (wp2s_pkg::SHIFT_BASE - ex);
        state_d = F_CONV;
      end
      F_CONV: begin
        if (stereo && !phase_q) begin
          held_d   = smp;
          phase_d  = 1'b1;
          gather_d = 32'd0;
          state_d  = F_IDLE;
        end else if (!full_i) begin
          push_o     = 1'b1;
          phase_d    = 1'b0;
          clr_pend_d = 1'b0;
          gather_d   = 32'd0;
          state_d    = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= F_IDLE;
      gather_q   <= 32'd0;
      idx_q      <= 3'd0;
      held_q     <= 16'd0;
      phase_q    <= 1'b0;
      clr_pend_q <= 1'b0;
      prod_q     <= 39'd0;
      sh_q       <= 8'd0;
    end else begin
      state_q    <= state_d;
      gather_q   <= gather_d;
      idx_q      <= idx_d;
      held_q     <= held_d;
      phase_q    <= phase_d;
      clr_pend_q <= clr_pend_d;
      prod_q     <= prod_d;
      sh_q       <= sh_d;
    end
  end

  `WP2S_ASSERT(a_idx_range, clk_i, rst_ni, idx_q <= 3'd3, "byte index beyond a partial sample")

endmodule

FILE: rtl/wp2s_back.sv
// rate accumulator and frame repeat with registered output
`timescale 1ns / 1ps
`include "wav_pcm_to_stereo16_resampler_macros.svh"
module wp2s_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  wp2s_pkg::cfg_t   cfg_i,
  input  logic             frm_valid_i,
  input  wp2s_pkg::frame_t frm_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [15:0]      left_sample_o,
  output logic [15:0]      right_sample_o,
  output logic             last_of_run_o
);

  typedef enum logic {
    B_IDLE,
    B_RUN
  } state_e;

  state_e      state_q, state_d;
  logic [17:0] acc_q, acc_d;
  logic [18:0] work_q, work_d;
  logic [3:0]  n_q, n_d;
  logic [15:0] left_q, left_d, right_q, right_d;
  logic        out_valid_q, out_valid_d;
  logic [15:0] out_left_q, out_left_d, out_right_q, out_right_d;
  logic        last_q, last_d;

  logic [18:0] in_rate, diff, acc_base;
  logic        emit, can_load;

  assign in_rate  = {2'b00, cfg_i.in_rate};
  assign diff     = work_q - in_rate;
  assign emit     = (work_q >= in_rate) && (n_q < wp2s_pkg::MAX_RUN);
  assign can_load = !out_valid_q || out_ready_i;
  assign acc_base = frm_i.clr_acc ? 19'd0 : {1'b0, acc_q};

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = out_left_q;
  assign right_sample_o = out_right_q;
  assign last_of_run_o  = last_q;

  // frame repeat loop
  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    work_d      = work_q;
    n_d         = n_q;
    left_d      = left_q;
    right_d     = right_q;
    out_left_d  = out_left_q;
    out_right_d = out_right_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;
    pop_o       = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (frm_valid_i) begin
          pop_o   = 1'b1;
          work_d  = acc_base + {2'b00, cfg_i.out_rate};
          n_d     = 4'd0;
          left_d  = frm_i.left;
          right_d = frm_i.right;
          state_d = B_RUN;
        end
      end
      B_RUN: begin
        if (emit) begin
          if (can_load) begin
            out_valid_d = 1'b1;
            out_left_d  = left_q;
            out_right_d = right_q;
            last_d      = !((diff >= in_rate) && (n_q < wp2s_pkg::MAX_RUN - 4'd1));
            work_d      = diff;
            n_d         = n_q + 4'd1;
          end
        end else begin
          // saturate when the run cap stopped the loop
          if (work_q >= in_rate) begin
            acc_d = (cfg_i.in_rate == 17'd0) ? 18'd0 : {1'b0, cfg_i.in_rate - 17'd1};
          end else begin
            acc_d = work_q[17:0];
          end
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      acc_q       <= 18'd0;
      work_q      <= 19'd0;
      n_q         <= 4'd0;
      left_q      <= 16'd0;
      right_q     <= 16'd0;
      out_valid_q <= 1'b0;
      out_left_q  <= 16'd0;
      out_right_q <= 16'd0;
      last_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      acc_q       <= acc_d;
      work_q      <= work_d;
      n_q         <= n_d;
      left_q      <= left_d;
      right_q     <= right_d;
      out_valid_q <= out_valid_d;
      out_left_q  <= out_left_d;
      out_right_q <= out_right_d;
      last_q      <= last_d;
    end
  end

  `WP2S_ASSERT(a_run_cap, clk_i, rst_ni, n_q <= wp2s_pkg::MAX_RUN, "run count beyond cap")
  `WP2S_ASSERT(a_idle_last, clk_i, rst_ni, !(state_q == B_IDLE && out_valid_q) || last_q, "pending item not marked last while idle")
  `WP2S_ASSERT_NEXT(a_pop_run, clk_i, rst_ni, pop_o, state_q == B_RUN && n_q == 4'd0, "frame taken without starting a run")

endmodule

FILE: sim/wav_pcm_to_stereo16_resampler_tb.sv
// self-checking testbench for the wav pcm to stereo16 resampler
`timescale 1ns / 1ps
module wav_pcm_to_stereo16_resampler_tb;

  localparam int GAP_MAX       = 14;
  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int RUN_CAP       = 12;
  localparam int RANDOM_BYTES  = 200;
  localparam int REPORT_MAX    = 10;

  localparam logic [7:0]  SIGN_FLIP = 8'h80;
  localparam logic [7:0]  EXP_INF   = 8'hFF;
  localparam logic [7:0]  EXP_UNITY = 8'd127;
  localparam logic [63:0] PCM_SCALE = 64'd32767;
  localparam logic [15:0] PCM_MAX   = 16'd32767;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic        last;
  } stereo_frame_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        start_of_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [15:0] left_sample_o;
  logic [15:0] right_sample_o;
  logic        last_of_run_o;

  wav_pcm_to_stereo16_resampler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .start_of_data_i(start_of_data_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o),
    .last_of_run_o  (last_of_run_o)
  );

  // register mirror
  logic [2:0]  fmt_q      = wp2s_pkg::FMT_PCM16;
  logic [1:0]  chans_q    = 2'd2;
  logic [16:0] in_rate_q  = 17'd48000;
  logic [16:0] out_rate_q = 17'd48000;

  // converter state mirror
  logic [31:0] gather_q    = '0;
  logic [2:0]  index_q     = '0;
  logic [15:0] held_left_q = '0;
  logic        right_due_q = 1'b0;
  logic [17:0] acc_q       = '0;

  stereo_frame_t pending_frames[$];

  int  mismatch_count = 0;
  int  frames_checked = 0;
  int  valid_bytes    = 0;
  int  settings_count = 0;
  int  cycle_count    = 0;
  bit  sender_quiet   = 1'b0;
  bit  receiver_quiet = 1'b0;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d frames still expected", cycle_count,
               pending_frames.size());
      $display("status: fail");
      $finish;
    end
  end

  function automatic int draw_gap(input bit quiet);
    return quiet ? 0 : $urandom_range(0, GAP_MAX);
  endfunction

  function automatic logic [2:0] bytes_per_sample(input logic [2:0] fmt);
    case (fmt)
      wp2s_pkg::FMT_PCM8:  return 3'd1;
      wp2s_pkg::FMT_PCM16: return 3'd2;
      wp2s_pkg::FMT_PCM24: return 3'd3;
      wp2s_pkg::FMT_PCM32: return 3'd4;
      wp2s_pkg::FMT_FLOAT: return 3'd4;
      default:             return 3'd0;
    endcase
  endfunction

  // float clamped to [-1,1], exact times 32767, truncated toward zero
  function automatic logic [15:0] float_to_pcm16(input logic [31:0] bits);
    logic        sgn;
    logic [7:0]  expo;
    logic [22:0] frac;
    logic [63:0] sig;
    logic [63:0] prod;
    int          shamt;
    logic [15:0] mag;
    sgn  = bits[31];
    expo = bits[30:23];
    frac = bits[22:0];
    if (expo == EXP_INF && frac != '0) return 16'h0000;
    if (expo >= EXP_UNITY) begin
      mag = PCM_MAX;
    end else begin
      if (expo == 8'd0) begin
        sig   = {41'd0, frac};
        shamt = 149;
      end else begin
        sig   = {40'd0, 1'b1, frac};
        shamt = 150 - int'(expo);
      end
      prod = sig * PCM_SCALE;
      mag  = (shamt > 63) ? 16'd0 : 16'(prod >> shamt);
    end
    return sgn ? 16'(-mag) : mag;
  endfunction

  function automatic logic [15:0] to_pcm16(input logic [2:0] fmt, input logic [31:0] g);
    case (fmt)
      wp2s_pkg::FMT_PCM8:  return {g[7:0] ^ SIGN_FLIP, 8'h00};
      wp2s_pkg::FMT_PCM16: return g[15:0];
      wp2s_pkg::FMT_PCM24: return g[23:8];
      wp2s_pkg::FMT_PCM32: return g[31:16];
      default:             return float_to_pcm16(g);
    endcase
  endfunction

  function automatic logic [31:0] pick_rate();
    case ($urandom_range(0, 5))
      0:       return 32'd8000;
      1:       return 32'd96000;
      2:       return 32'd44100;
      3:       return 32'd48000;
      default: return 32'($urandom_range(8000, 96000));
    endcase
  endfunction

  // works out the frames that one accepted byte causes
  task automatic predict_byte(input logic [7:0] b, input logic sod);
    logic [2:0]    need;
    logic [15:0]   smp;
    logic [15:0]   left;
    logic [31:0]   sum;
    logic          stereo;
    int            n;
    stereo_frame_t fr;
    if (sod) begin
      gather_q    = '0;
      index_q     = '0;
      held_left_q = '0;
      right_due_q = 1'b0;
      acc_q       = '0;
    end
    need = bytes_per_sample(fmt_q);
    if (need == 3'd0) return;
    if (index_q < 3'd4) gather_q = gather_q | (32'(b) << (8 * index_q));
    index_q = index_q + 3'd1;
    if (index_q < need) return;
    smp      = to_pcm16(fmt_q, gather_q);
    gather_q = '0;
    index_q  = '0;
    // left of a stereo pair waits for its partner
    stereo = (chans_q >= 2'd2);
    if (stereo && !right_due_q) begin
      held_left_q = smp;
      right_due_q = 1'b1;
      return;
    end
    left        = stereo ? held_left_q : smp;
    right_due_q = 1'b0;
    // zero-order hold: repeat the frame while the accumulator covers the input rate
    sum = 32'(acc_q) + 32'(out_rate_q);
    n   = 0;
    while (sum >= 32'(in_rate_q) && n < RUN_CAP) begin
      sum      = sum - 32'(in_rate_q);
      n++;
      fr.left  = left;
      fr.right = smp;
      fr.last  = !(sum >= 32'(in_rate_q) && n < RUN_CAP);
      pending_frames.push_back(fr);
    end
    if (sum >= 32'(in_rate_q)) sum = (in_rate_q == '0) ? 32'd0 : 32'(in_rate_q) - 32'd1;
    acc_q = sum[17:0];
  endtask

  // apb write, setup then access
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      wp2s_pkg::REG_FORMAT:   fmt_q      = val[2:0];
      wp2s_pkg::REG_CHANNELS: chans_q    = val[1:0];
      wp2s_pkg::REG_IN_RATE:  in_rate_q  = val[16:0];
      wp2s_pkg::REG_OUT_RATE: out_rate_q = val[16:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // sends one item; valid stays high into the next item when there is no gap
  task automatic send_byte(input logic [7:0] b, input logic sod);
    int gap;
    gap = draw_gap(sender_quiet);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    start_of_data_i <= sod;
    do @(posedge clk_i); while (!in_ready_o);
    if (bytes_per_sample(fmt_q) != 3'd0) valid_bytes++;
    predict_byte(b, sod);
  endtask

  // little-endian bytes of one sample word
  task automatic send_word(input logic [31:0] w, input int nbytes, input logic sod_first,
                           input bit noisy);
    logic sod;
    for (int k = 0; k < nbytes; k++) begin
      sod = (k == 0) ? sod_first : (noisy && $urandom_range(0, 49) == 0);
      send_byte(w[8*k +: 8], sod);
    end
  endtask

  // drains all expected frames, then lets the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // receiver with random stalls
  initial begin
    int gap;
    forever begin
      gap = draw_gap(receiver_quiet);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compare each accepted frame with the oldest expected one
  always @(posedge clk_i) begin
    stereo_frame_t exp_fr;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_frames.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
          $display("unexpected frame: L %h R %h last %b", left_sample_o, right_sample_o,
                   last_of_run_o);
      end else begin
        exp_fr = pending_frames.pop_front();
        frames_checked++;
        if (left_sample_o !== exp_fr.left || right_sample_o !== exp_fr.right ||
            last_of_run_o !== exp_fr.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("frame mismatch: expected L %h R %h last %b, got L %h R %h last %b",
                     exp_fr.left, exp_fr.right, exp_fr.last,
                     left_sample_o, right_sample_o, last_of_run_o);
        end
      end
    end
  end

  // reset configuration, stereo 16-bit extremes
  task automatic test_default_pcm16();
    send_word(32'h0000_8000, 2, 1'b1, 1'b0);
    send_word(32'h0000_7FFF, 2, 1'b0, 1'b0);
    wait_idle();
  endtask

  // unknown format ignores the byte
  task automatic test_unknown_format();
    write_reg(wp2s_pkg::REG_FORMAT, 32'd5);
    send_word(32'h0000_00A5, 1, 1'b1, 1'b0);
    wait_idle();
  endtask

  // 8-bit mono extremes
  task automatic test_pcm8_mono();
    write_reg(wp2s_pkg::REG_FORMAT, 32'(wp2s_pkg::FMT_PCM8));
    write_reg(wp2s_pkg::REG_CHANNELS, 32'd1);
    send_word(32'h0000_0000, 1, 1'b1, 1'b0);
    send_word(32'h0000_00FF, 1, 1'b0, 1'b0);
    wait_idle();
  endtask

  // format change mid-sample, then mono while a right sample is due
  task automatic test_format_switch();
    write_reg(wp2s_pkg::REG_CHANNELS, 32'd2);
    write_reg(wp2s_pkg::REG_FORMAT, 32'(wp2s_pkg::FMT_PCM24));
    send_word(32'h0000_2211, 2, 1'b1, 1'b0);
    wait_idle();
    write_reg(wp2s_pkg::REG_FORMAT, 32'(wp2s_pkg::FMT_PCM16));
    send_word(32'h0000_0033, 1, 1'b0, 1'b0);
    wait_idle();
    write_reg(wp2s_pkg::REG_CHANNELS, 32'd1);
    write_reg(wp2s_pkg::REG_FORMAT, 32'(wp2s_pkg::FMT_PCM8));
    send_word(32'h0000_0044, 1, 1'b0, 1'b0);
    wait_idle();
  endtask

  // float nan and a value just inside -1, channel count zero as mono
  task automatic test_float_mono();
    write_reg(wp2s_pkg::REG_CHANNELS, 32'd0);
    write_reg(wp2s_pkg::REG_FORMAT, 32'(wp2s_pkg::FMT_FLOAT));
    send_word(32'h7FC0_0001, 4, 1'b1, 1'b0);
    send_word(32'hBF7F_FFFF, 4, 1'b0, 1'b0);
    wait_idle();
  endtask

  // twelve-frame runs, run cap with accumulator saturation, zero input rate
  task automatic test_run_cap();
    write_reg(wp2s_pkg::REG_FORMAT, 32'(wp2s_pkg::FMT_PCM8));
    write_reg(wp2s_pkg::REG_IN_RATE, 32'd8000);
    write_reg(wp2s_pkg::REG_OUT_RATE, 32'd96000);
    send_word(32'h0000_0001, 1, 1'b1, 1'b0);
    wait_idle();
    write_reg(wp2s_pkg::REG_IN_RATE, 32'd5000);
    send_word(32'h0000_00FE, 1, 1'b0, 1'b0);
    send_word(32'h0000_007F, 1, 1'b0, 1'b0);
    wait_idle();
    write_reg(wp2s_pkg::REG_IN_RATE, 32'd0);
    send_word(32'h0000_0080, 1, 1'b0, 1'b0);
    wait_idle();
  endtask

  // random settings, well-formed sample streams with some noise and partial tails
  task automatic test_random_streams();
    int          samples;
    int          nb;
    logic [2:0]  f;
    logic        sgn;
    logic [31:0] w;
    while (valid_bytes < RANDOM_BYTES) begin
      f = ($urandom_range(0, 11) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      if ($urandom_range(0, 3) != 0) write_reg(wp2s_pkg::REG_FORMAT, 32'(f));
      if ($urandom_range(0, 1) == 0)
        write_reg(wp2s_pkg::REG_CHANNELS, 32'($urandom_range(0, 3)));
      if ($urandom_range(0, 1) == 0) write_reg(wp2s_pkg::REG_IN_RATE, pick_rate());
      if ($urandom_range(0, 1) == 0) write_reg(wp2s_pkg::REG_OUT_RATE, pick_rate());
      settings_count++;
      sender_quiet   = ($urandom_range(0, 3) == 0);
      receiver_quiet = ($urandom_range(0, 3) == 0);
      samples = $urandom_range(2, 14);
      nb      = int'(bytes_per_sample(fmt_q));
      for (int k = 0; k < samples; k++) begin
        sgn = 1'($urandom_range(0, 1));
        if (fmt_q == wp2s_pkg::FMT_FLOAT) begin
          // bias toward the float corners
          case ($urandom_range(0, 7))
            0:       w = {sgn, EXP_INF, 23'($urandom_range(1, 23'h7FFFFF))};
            1:       w = {sgn, EXP_INF, 23'd0};
            2:       w = {sgn, 31'd0};
            3:       w = {sgn, 8'd0, 23'($urandom)};
            4:       w = {sgn, 8'($urandom_range(127, 254)), 23'($urandom)};
            default: w = {sgn, 8'($urandom_range(100, 126)), 23'($urandom)};
          endcase
        end else begin
          case ($urandom_range(0, 5))
            0:       w = '0;
            1:       w = '1;
            default: w = $urandom;
          endcase
        end
        send_word(w, (nb == 0) ? $urandom_range(1, 4) : nb,
                  (k == 0) && ($urandom_range(0, 3) != 0), 1'b1);
      end
      // trailing partial sample now and then
      if (nb > 1 && $urandom_range(0, 3) == 0)
        send_word($urandom, $urandom_range(1, nb - 1), 1'b0, 1'b1);
      wait_idle();
    end
    sender_quiet   = 1'b0;
    receiver_quiet = 1'b0;
  endtask

  initial begin
    rst_ni          <= 1'b0;
    psel            <= 1'b0;
    penable         <= 1'b0;
    pwrite          <= 1'b0;
    paddr           <= '0;
    pwdata          <= '0;
    in_valid_i      <= 1'b0;
    data_byte_i     <= '0;
    start_of_data_i <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_pcm16();
    test_unknown_format();
    test_pcm8_mono();
    test_format_switch();
    test_float_mono();
    test_run_cap();
    test_random_streams();
    wait_idle();

    if (pending_frames.size() != 0) begin
      mismatch_count++;
      $display("%0d expected frames never arrived", pending_frames.size());
    end
    $display("run covered %0d data bytes and %0d checked frames over %0d random settings",
             valid_bytes, frames_checked, settings_count);
    $display("%0d mismatches in %0d cycles", mismatch_count, cycle_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/wp2s_pkg.sv
rtl/wp2s_fifo.sv
rtl/wp2s_front.sv
rtl/wp2s_back.sv
rtl/wav_pcm_to_stereo16_resampler.sv
sim/wav_pcm_to_stereo16_resampler_tb.sv
